FILE: rtl/mrc_pkg.sv
package mrc_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int INDEX_W  = 7;
    localparam int STATUS_W = 4;
    localparam int POS_W    = 9;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_TRANSACTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_UNIT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_COUNT  = 2'd2;

    // Function codes
    localparam logic [BYTE_W-1:0] FC_READ     = 8'h03;
    localparam logic [BYTE_W-1:0] FC_READ_EXC = 8'h83;

    // Frame layout
    localparam int MIN_FRAME     = 7;
    localparam int MBAP_PREFIX   = 6;
    localparam int MIN_REMAINING = 3;
    localparam int DATA_START    = 9;

    localparam logic [POS_W-1:0] OFS_TRANS_HI = 9'd0;
    localparam logic [POS_W-1:0] OFS_TRANS_LO = 9'd1;
    localparam logic [POS_W-1:0] OFS_PROTO_HI = 9'd2;
    localparam logic [POS_W-1:0] OFS_PROTO_LO = 9'd3;
    localparam logic [POS_W-1:0] OFS_LEN_HI   = 9'd4;
    localparam logic [POS_W-1:0] OFS_LEN_LO   = 9'd5;
    localparam logic [POS_W-1:0] OFS_UNIT     = 9'd6;
    localparam logic [POS_W-1:0] OFS_FUNC     = 9'd7;
    localparam logic [POS_W-1:0] OFS_BCOUNT   = 9'd8;

    // Result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Frame status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 4'd0;
    localparam logic [STATUS_W-1:0] ST_ARGUMENT   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_LENGTH     = 4'd2;
    localparam logic [STATUS_W-1:0] ST_TRANSACTION = 4'd3;
    localparam logic [STATUS_W-1:0] ST_PROTOCOL   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_UNIT       = 4'd5;
    localparam logic [STATUS_W-1:0] ST_EXCEPTION  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_FUNCTION   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_BYTE_COUNT = 4'd8;

    typedef struct packed {
        logic                result_kind;
        logic [WORD_W-1:0]   word_value;
        logic [INDEX_W-1:0]  word_index;
        logic [STATUS_W-1:0] frame_status;
        logic [BYTE_W-1:0]   exception_value;
        logic                last;
    } t_result;

endpackage

FILE: rtl/mrc_in_if.sv
interface mrc_in_if import mrc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

FILE: rtl/mrc_out_if.sv
interface mrc_out_if import mrc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [WORD_W-1:0]   word_value;
    logic [INDEX_W-1:0]  word_index;
    logic [STATUS_W-1:0] frame_status;
    logic [BYTE_W-1:0]   exception_value;
    logic                last;

    modport source (
        output valid, output result_kind, output word_value, output word_index,
        output frame_status, output exception_value, output last, input ready
    );
    modport sink (
        input valid, input result_kind, input word_value, input word_index,
        input frame_status, input exception_value, input last, output ready
    );
endinterface

FILE: rtl/modbus_read_response_checker.sv
// Modbus TCP read-holding-registers response checker.
// Input channel i_in carries one response byte per request (data_byte) with
// frame_end marking the final byte of the frame. Output channel o_out carries
// result requests: a register word (result_kind 0) for each completed
// big-endian data word up to register_count, and one status (result_kind 1,
// last 1) per frame. Words are only trustworthy if the frame status is ok.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
// (0 expected transaction, 1 expected unit, 2 register count); the user must
// write it only while the block is idle, which the block does not enforce.
// Results are registered into the queue; a byte that finishes a word and ends the
// frame pushes two. Throughput: one byte per cycle while i_in.ready is high; the
// queue drains one result per cycle while o_out.ready is high. i_in.ready drops
// only while the four-entry result queue lacks room for two results, i.e. while
// the receiver stalls o_out. Reset (synchronous, active low) clears frame state
// and the queue and loads the register defaults: transaction 0, unit 1,
// register count 1. Bytes past MAX_FRAME_BYTES are dropped and force a length status.
module modbus_read_response_checker
    import mrc_pkg::*;
#(
    parameter int MAX_REGISTERS   = 125,
    parameter int MAX_FRAME_BYTES = 259
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mrc_in_if.sink               i_in,
    mrc_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int REM_MAX = MIN_REMAINING + 2 * MAX_REGISTERS;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Configuration registers
    logic [WORD_W-1:0]  r_exp_trans;
    logic [BYTE_W-1:0]  r_exp_unit;
    logic [INDEX_W-1:0] r_reg_count;

    // Per-frame state
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic               r_ovf,    n_ovf;
    logic [WORD_W-1:0]  r_trans,  n_trans;
    logic [WORD_W-1:0]  r_proto,  n_proto;
    logic [WORD_W-1:0]  r_rem,    n_rem;
    logic [BYTE_W-1:0]  r_unit,   n_unit;
    logic [BYTE_W-1:0]  r_func,   n_func;
    logic [BYTE_W-1:0]  r_bcount, n_bcount;
    logic [BYTE_W-1:0]  r_hold,   n_hold;
    logic [INDEX_W-1:0] r_words,  n_words;

    // Result queue
    t_result              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;

    logic               in_acc;
    logic               out_acc;
    logic               word_emit;
    logic               status_emit;
    logic [WORD_W-1:0]  word_val;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]  exc_val;
    t_result            e_word, e_status;

    // Accept a request only while two queue slots are guaranteed free.
    assign i_in.ready = (r_count <= Q_CNT_W'(Q_DEPTH - 2));
    assign in_acc     = i_in.valid & i_in.ready;
    assign out_acc    = o_out.valid & o_out.ready;

    // Byte capture and word pairing
    always_comb begin
        n_pos    = r_pos;
        n_ovf    = r_ovf;
        n_trans  = r_trans;
        n_proto  = r_proto;
        n_rem    = r_rem;
        n_unit   = r_unit;
        n_func   = r_func;
        n_bcount = r_bcount;
        n_hold   = r_hold;
        n_words  = r_words;
        word_emit = 1'b0;
        word_val  = {r_hold, i_in.data_byte};
        if (r_ovf || (32'(r_pos) >= MAX_FRAME_BYTES)) begin
            n_ovf = 1'b1;
        end else begin
            case (r_pos)
                OFS_TRANS_HI: n_trans  = {i_in.data_byte, 8'h00};
                OFS_TRANS_LO: n_trans  = r_trans | {8'h00, i_in.data_byte};
                OFS_PROTO_HI: n_proto  = {i_in.data_byte, 8'h00};
                OFS_PROTO_LO: n_proto  = r_proto | {8'h00, i_in.data_byte};
                OFS_LEN_HI:   n_rem    = {i_in.data_byte, 8'h00};
                OFS_LEN_LO:   n_rem    = r_rem | {8'h00, i_in.data_byte};
                OFS_UNIT:     n_unit   = i_in.data_byte;
                OFS_FUNC:     n_func   = i_in.data_byte;
                OFS_BCOUNT:   n_bcount = i_in.data_byte;
                default: begin
                    // Odd positions from the data start hold the high byte.
                    if (r_pos[0]) begin
                        n_hold = i_in.data_byte;
                    end else if (r_words < r_reg_count) begin
                        word_emit = 1'b1;
                        n_words   = r_words + INDEX_W'(1);
                    end
                end
            endcase
            n_pos = r_pos + POS_W'(1);
        end
    end

    // Frame check on the state including the final byte
    always_comb begin
        status  = ST_OK;
        exc_val = '0;
        if ((r_reg_count == '0) || (32'(r_reg_count) > MAX_REGISTERS)) begin
            status = ST_ARGUMENT;
        end else if (n_ovf || (32'(n_pos) < MIN_FRAME) ||
                     (32'(n_pos) > MAX_FRAME_BYTES)) begin
            status = ST_LENGTH;
        end else if (n_trans != r_exp_trans) begin
            status = ST_TRANSACTION;
        end else if (n_proto != '0) begin
            status = ST_PROTOCOL;
        end else if (n_unit != r_exp_unit) begin
            status = ST_UNIT;
        end else if ((32'(n_rem) < MIN_REMAINING) || (32'(n_rem) > REM_MAX)) begin
            status = ST_LENGTH;
        end else if ((17'(n_pos)) != (17'(n_rem) + 17'(MBAP_PREFIX))) begin
            status = ST_LENGTH;
        end else if (n_func == FC_READ_EXC) begin
            if ((n_rem != WORD_W'(MIN_REMAINING)) || (n_bcount == '0)) begin
                status = ST_LENGTH;
            end else begin
                status  = ST_EXCEPTION;
                exc_val = n_bcount;
            end
        end else if (n_func != FC_READ) begin
            status = ST_FUNCTION;
        end else if (n_bcount != {r_reg_count, 1'b0}) begin
            status = ST_BYTE_COUNT;
        end else if (n_rem != (WORD_W'(MIN_REMAINING) + {8'h00, r_reg_count, 1'b0})) begin
            status = ST_LENGTH;
        end
    end

    assign status_emit = i_in.frame_end;

    always_comb begin
        e_word.result_kind     = KIND_WORD;
        e_word.word_value      = word_val;
        e_word.word_index      = r_words;
        e_word.frame_status    = ST_OK;
        e_word.exception_value = '0;
        e_word.last            = 1'b0;

        e_status.result_kind     = KIND_STATUS;
        e_status.word_value      = '0;
        e_status.word_index      = '0;
        e_status.frame_status    = status;
        e_status.exception_value = exc_val;
        e_status.last            = 1'b1;
    end

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_trans <= '0;
            r_exp_unit  <= BYTE_W'(1);
            r_reg_count <= INDEX_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXP_TRANSACTION: r_exp_trans <= i_cfg_data;
                CFG_EXP_UNIT:        r_exp_unit  <= i_cfg_data[BYTE_W-1:0];
                CFG_REGISTER_COUNT:  r_reg_count <= i_cfg_data[INDEX_W-1:0];
                default:             r_exp_trans <= r_exp_trans;
            endcase
        end
    end

    // Frame state: advance on each request, clear after frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_in.frame_end)) begin
            r_pos    <= '0;
            r_ovf    <= 1'b0;
            r_trans  <= '0;
            r_proto  <= '0;
            r_rem    <= '0;
            r_unit   <= '0;
            r_func   <= '0;
            r_bcount <= '0;
            r_hold   <= '0;
            r_words  <= '0;
        end else if (in_acc) begin
            r_pos    <= n_pos;
            r_ovf    <= n_ovf;
            r_trans  <= n_trans;
            r_proto  <= n_proto;
            r_rem    <= n_rem;
            r_unit   <= n_unit;
            r_func   <= n_func;
            r_bcount <= n_bcount;
            r_hold   <= n_hold;
            r_words  <= n_words;
        end
    end

    // Result queue: push word then status, pop one per cycle while o_out.ready is high
    logic [Q_CNT_W-1:0] push_n;
    always_comb begin
        push_n = '0;
        if (in_acc) begin
            push_n = Q_CNT_W'(word_emit) + Q_CNT_W'(status_emit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (word_emit) begin
                r_q[r_wr_ptr] <= e_word;
                if (status_emit) begin
                    r_q[r_wr_ptr + Q_PTR_W'(1)] <= e_status;
                end
            end else if (status_emit) begin
                r_q[r_wr_ptr] <= e_status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[Q_PTR_W-1:0];
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + push_n - Q_CNT_W'(out_acc);
        end
    end

    assign o_out.valid           = (r_count != '0);
    assign o_out.result_kind     = r_q[r_rd_ptr].result_kind;
    assign o_out.word_value      = r_q[r_rd_ptr].word_value;
    assign o_out.word_index      = r_q[r_rd_ptr].word_index;
    assign o_out.frame_status    = r_q[r_rd_ptr].frame_status;
    assign o_out.exception_value = r_q[r_rd_ptr].exception_value;
    assign o_out.last            = r_q[r_rd_ptr].last;

endmodule
